### rtl/mecodo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum odometry package
// Shared formats, constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mecodo_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int WHEEL_COUNT  = 4;
	localparam int DEAD_BAND    = (1 << FRAC_BITS) / 100;
	localparam int TURN_SCALE   = 683565276;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_STEPS    = 50;
	localparam int POS_SHIFT    = 19;
	localparam int CS_W         = 31;

	typedef enum logic [1:0] {
		REG_WHEEL_RADIUS    = 2'd0,
		REG_BASE_SUM        = 2'd1,
		REG_HEADING_START   = 2'd2,
		REG_ANGLE_REFERENCE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] speed_front_left;
		logic signed [31:0] speed_front_right;
		logic signed [31:0] speed_rear_left;
		logic signed [31:0] speed_rear_right;
		logic signed [31:0] angle_front_left;
		logic signed [31:0] angle_front_right;
		logic signed [31:0] angle_rear_left;
		logic signed [31:0] angle_rear_right;
		logic        [15:0] period;
	} in_t;

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] heading;
		logic               slipping;
	} out_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/mecanum_odometry_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum odometry integrator
// Dead-reckons vehicle pose from four wheel speeds and angles per request.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   in_data (in_t)
//  out      out_valid / out_ready out_data (out_t)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request runs through the 50-step restoring divider for the heading quotient
// and then waits for the CORDIC; one shared multiplier does all products.
// in_ready is high only while the sequencer idles. The result sits in an
// output register, so a new request is taken while it waits; a stalled output
// holds the sequencer at its last step. Reset clears control state, the
// previous speeds and the position sums, clears the heading start and angle
// reference and loads default wheel radius and base sum values.
module mecanum_odometry_integrator
	import mecodo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_RP   = 17'h00002,
		ST_NUM  = 17'h00004,
		ST_DSET = 17'h00008,
		ST_DIV  = 17'h00010,
		ST_HSAT = 17'h00020,
		ST_TURN = 17'h00040,
		ST_CST  = 17'h00080,
		ST_CORD = 17'h00100,
		ST_MX1  = 17'h00200,
		ST_MX2  = 17'h00400,
		ST_MX3  = 17'h00800,
		ST_MX4  = 17'h01000,
		ST_MX5  = 17'h02000,
		ST_MX6  = 17'h04000,
		ST_MX7  = 17'h08000,
		ST_FIN  = 17'h10000
	} state_t;

	localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

	state_t             state_q;
	logic [15:0]        wheel_radius_q;
	logic [23:0]        base_sum_q;
	logic signed [31:0] heading_start_q;
	logic signed [31:0] angle_reference_q;
	logic signed [31:0] prev_q [WHEEL_COUNT];
	logic signed [31:0] accx_q, accy_q;
	logic               out_valid_q;
	out_t               out_q;

	logic signed [31:0] w_q [WHEEL_COUNT];
	logic signed [34:0] diff_q;
	logic [15:0]        period_q;
	logic [15:0]        rp_q;
	logic signed [33:0] s02_q, s13_q;
	logic               slip_q;
	logic signed [70:0] prod_q;
	logic               neg_q;
	logic [49:0]        dvd_q;
	logic [23:0]        rem_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] h_q;
	logic signed [57:0] acc_q;
	logic signed [39:0] dx_q, dy_q;

	logic signed [31:0] spd [WHEEL_COUNT];
	logic signed [31:0] w_d [WHEEL_COUNT];
	logic signed [34:0] diff_d;
	logic signed [39:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [70:0] prod_d;
	logic signed [51:0] num;
	logic [51:0]        mag;
	logic [23:0]        divisor;
	logic [24:0]        trial, trial_sub;
	logic               ge;
	logic signed [51:0] qs, hsum;
	logic signed [31:0] hsat;
	logic signed [57:0] dsum, dsh;
	logic signed [70:0] pstep;
	logic signed [33:0] slip_sum;
	logic               cor_start, cor_done;
	logic signed [CS_W-1:0] ca, cb;

	mecodo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.turn    (prod_q[FRAC_BITS+31:FRAC_BITS]),
		.done    (cor_done),
		.cs_sum  (ca),
		.cs_diff (cb)
	);

	assign cor_start = (state_q == ST_CST);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		spd[0] = in_data.speed_front_left;
		spd[1] = in_data.speed_front_right;
		spd[2] = in_data.speed_rear_left;
		spd[3] = in_data.speed_rear_right;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			w_d[i] = ((spd[i] <= 32'sd0 + 32'(DEAD_BAND)) && (spd[i] >= -32'(DEAD_BAND)))
				? 32'sd0 : spd[i];
		end
		diff_d = 35'(in_data.angle_front_left) - 35'(in_data.angle_front_right)
			- 35'(in_data.angle_rear_left) + 35'(in_data.angle_rear_right)
			- 35'(angle_reference_q);
		slip_sum = 34'(w_q[0]) + 34'(w_q[1]) - 34'(w_q[2]) - 34'(w_q[3]);

		num     = prod_q[51:0];
		mag     = num[51] ? 52'(-num) : 52'(num);
		divisor = (base_sum_q == 24'd0) ? 24'd1 : base_sum_q;
		trial   = {rem_q, dvd_q[49]};
		ge      = (trial >= {1'b0, divisor});
		trial_sub = trial - {1'b0, divisor};

		qs   = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
		hsum = qs + 52'(heading_start_q);
		if (hsum > 52'sd2147483647) begin
			hsat = 32'sh7FFF_FFFF;
		end else if (hsum < -52'sd2147483648) begin
			hsat = 32'sh8000_0000;
		end else begin
			hsat = hsum[31:0];
		end

		dsum  = acc_q + $signed(prod_q[57:0]);
		dsh   = dsum >>> FRAC_BITS;
		pstep = prod_q >>> POS_SHIFT;

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RP: begin
				mul_a = $signed({24'd0, period_q});
				mul_b = $signed({15'd0, wheel_radius_q});
			end
			ST_NUM: begin
				mul_a = 40'(diff_q);
				mul_b = $signed({15'd0, wheel_radius_q});
			end
			ST_TURN: begin
				mul_a = 40'(h_q);
				mul_b = 31'(TURN_SCALE);
			end
			ST_MX1: begin
				mul_a = 40'(s02_q);
				mul_b = 31'(ca);
			end
			ST_MX2: begin
				mul_a = 40'(s13_q);
				mul_b = 31'(cb);
			end
			ST_MX3: begin
				mul_a = 40'(s02_q);
				mul_b = 31'(cb);
			end
			ST_MX4: begin
				mul_a = 40'(s13_q);
				mul_b = 31'(ca);
			end
			ST_MX5: begin
				mul_a = dx_q;
				mul_b = $signed({15'd0, rp_q});
			end
			ST_MX6: begin
				mul_a = dy_q;
				mul_b = $signed({15'd0, rp_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_d = mul_a * mul_b;
	end

	// Control, configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			wheel_radius_q    <= 16'd3277;
			base_sum_q        <= 24'd32768;
			heading_start_q   <= '0;
			angle_reference_q <= '0;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				prev_q[i] <= '0;
			end
			accx_q      <= '0;
			accy_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WHEEL_RADIUS:    wheel_radius_q    <= cfg_data[15:0];
					REG_BASE_SUM:        base_sum_q        <= cfg_data[23:0];
					REG_HEADING_START:   heading_start_q   <= cfg_data;
					REG_ANGLE_REFERENCE: angle_reference_q <= cfg_data;
					default: ;
				endcase
			end
			// In the final step the output register is reloaded instead.
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_RP;
				ST_RP:   state_q <= ST_NUM;
				ST_NUM:  state_q <= ST_DSET;
				ST_DSET: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) state_q <= ST_HSAT;
				end
				ST_HSAT: state_q <= ST_TURN;
				ST_TURN: state_q <= ST_CST;
				ST_CST:  state_q <= ST_CORD;
				ST_CORD: if (cor_done) state_q <= ST_MX1;
				ST_MX1:  state_q <= ST_MX2;
				ST_MX2:  state_q <= ST_MX3;
				ST_MX3:  state_q <= ST_MX4;
				ST_MX4:  state_q <= ST_MX5;
				ST_MX5:  state_q <= ST_MX6;
				ST_MX6: begin
					accx_q  <= accx_q + pstep[31:0];
					state_q <= ST_MX7;
				end
				ST_MX7: begin
					accy_q <= accy_q + pstep[31:0];
					for (int i = 0; i < WHEEL_COUNT; i++) begin
						prev_q[i] <= w_q[i];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					for (int i = 0; i < WHEEL_COUNT; i++) begin
						w_q[i] <= w_d[i];
					end
					diff_q   <= diff_d;
					period_q <= in_data.period;
				end
			end
			ST_RP: begin
				s02_q  <= 34'(prev_q[0]) + 34'(w_q[0]) + 34'(prev_q[2]) + 34'(w_q[2]);
				s13_q  <= 34'(prev_q[1]) + 34'(w_q[1]) + 34'(prev_q[3]) + 34'(w_q[3]);
				slip_q <= (slip_sum > 34'(DEAD_BAND));
			end
			ST_NUM: rp_q <= prod_q[31:16];
			ST_DSET: begin
				neg_q <= num[51];
				dvd_q <= mag[51:2];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? trial_sub[23:0] : trial[23:0];
				dvd_q <= {dvd_q[48:0], ge};
			end
			ST_HSAT: h_q <= hsat;
			ST_MX2:  acc_q <= -$signed(prod_q[57:0]);
			ST_MX3:  dx_q <= dsh[39:0];
			ST_MX4:  acc_q <= $signed(prod_q[57:0]);
			ST_MX5:  dy_q <= dsh[39:0];
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q.position_x <= accx_q;
					out_q.position_y <= accy_q;
					out_q.heading    <= h_q;
					out_q.slipping   <= slip_q;
				end
			end
			default: ;
		endcase
	end

	a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_CORD))
		else $error("CORDIC finished outside its wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RP))
		else $error("accepted request did not start the sequencer");

	a_accx_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(accx_q) |-> ($past(state_q) == ST_MX6))
		else $error("x position changed outside its update step");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider ran past its step count");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && (!out_valid_q || out_ready)) |=> out_valid_q)
		else $error("finished request did not reach the output register");

endmodule

### rtl/mecodo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Turns a 32-bit turn fraction into cos+sin and cos-sin, one step per cycle.
// ----------------------------------------------------------------------------
module mecodo_cordic
	import mecodo_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            turn,
	output logic                   done,
	output logic signed [CS_W-1:0] cs_sum,
	output logic signed [CS_W-1:0] cs_diff
);

	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic               flip_q;
	logic signed [33:0] x_q, y_q, z_q;

	logic [31:0]        turn_adj;
	logic               flip;
	logic signed [33:0] dx, dy, at;
	logic signed [34:0] xf, yf;
	logic signed [35:0] sum, dif;

	always_comb begin
		flip     = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
		turn_adj = flip ? (turn + 32'h8000_0000) : turn;
		dx       = y_q >>> cnt_q;
		dy       = x_q >>> cnt_q;
		at       = $signed({4'b0, atan_turn(cnt_q)});
		xf       = flip_q ? -35'(x_q) : 35'(x_q);
		yf       = flip_q ? -35'(y_q) : 35'(y_q);
		sum      = 36'(xf) + 36'(yf);
		dif      = 36'(xf) - 36'(yf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 34'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= {{2{turn_adj[31]}}, turn_adj};
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cs_sum  = CS_W'(sum >>> (30 - FRAC_BITS));
	assign cs_diff = CS_W'(dif >>> (30 - FRAC_BITS));

endmodule
